// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the RTL that checks itself.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, disabled while reset is held.
`define TJH_ASSERT(lbl, clk_s, rstn_s, prop) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) prop) \
    else $error("tjh assertion failed");

// Clocked check with its own message.
`define TJH_ASSERT_MSG(lbl, clk_s, rstn_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) prop) \
    else $error(msg);

`endif

// ===== hw/rtl/tjh_pkg.sv =====
// Shared constants, types and the bin classifier for the tick jitter histogram.
`timescale 1ns / 1ps

package tjh_pkg;

  localparam int DATA_W               = 32;
  localparam int RATE_W               = 20;
  localparam int NUM_BINS             = 16;
  localparam int BIN_W                = 4;
  localparam int TICKS_PER_SECOND_DEF = 1000;
  localparam int US_SCALE             = 100000;
  localparam int CFG_IDX_W            = 1;

  localparam logic [RATE_W-1:0] NOMINAL_NUM     = 20'd1000000;
  localparam logic [RATE_W-1:0] SAMPLE_RATE_RST = 20'd1000;
  localparam logic [DATA_W-1:0] CPJ_RST         = 32'd1000000;

  // floor(x / 10) == (x * RECIP10) >> RECIP10_SHIFT for every 32-bit x
  localparam logic [DATA_W-1:0] RECIP10       = 32'hCCCC_CCCD;
  localparam int                RECIP10_SHIFT = 35;

  localparam logic ACT_TICK = 1'b0;
  localparam logic ACT_READ = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_RATE      = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_CYCLES_PER_JIFFY = 1'b1;

  localparam logic [DATA_W-1:0] BIN_EDGES [NUM_BINS] = '{
    32'd0,    32'd1,    32'd2,     32'd5,     32'd10,    32'd20,
    32'd50,   32'd100,  32'd200,   32'd500,   32'd1000,  32'd2000,
    32'd5000, 32'd10000, 32'd20000, 32'd50000
  };

  typedef struct packed {
    logic start;
    logic short_run;
  } div_cmd_t;

  typedef struct packed {
    logic              rd_en;
    logic              wr_en;
    logic [BIN_W-1:0]  addr;
    logic [DATA_W-1:0] wr_data;
  } bin_req_t;

  function automatic logic [BIN_W-1:0] classify(input logic [DATA_W-1:0] jit);
    logic [BIN_W-1:0] b;
    b = '0;
    for (int i = 1; i < NUM_BINS; i++) begin
      if (jit >= BIN_EDGES[i]) b = BIN_W'(i);
    end
    return b;
  endfunction

endpackage

// ===== hw/rtl/tjh_div.sv =====
// Iterative restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module tjh_div #(
  parameter int NUM_W = tjh_pkg::DATA_W + 7
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  tjh_pkg::div_cmd_t           cmd,
  input  logic [NUM_W-1:0]            num,
  input  logic [tjh_pkg::DATA_W-1:0]  den,
  output logic [NUM_W-1:0]            quot,
  output logic                        done
);

  localparam int CNT_W = $clog2(NUM_W + 1);
  localparam int DW    = tjh_pkg::DATA_W;
  localparam int RW    = tjh_pkg::RATE_W;

  logic [CNT_W-1:0] cnt_r;
  logic             done_r;
  logic [NUM_W-1:0] q_r;
  logic [DW:0]      rem_r;
  logic [DW-1:0]    den_r;
  logic [DW:0]      shifted;
  logic             fits;

  assign shifted = {rem_r[DW-1:0], q_r[NUM_W-1]};
  assign fits    = (shifted >= {1'b0, den_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= !cmd.start && (cnt_r == CNT_W'(1));
      if (cmd.start) begin
        cnt_r <= cmd.short_run ? CNT_W'(RW) : CNT_W'(NUM_W);
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      q_r   <= cmd.short_run ? {num[RW-1:0], {(NUM_W-RW){1'b0}}} : num;
      rem_r <= '0;
      den_r <= den;
    end else if (cnt_r != '0) begin
      q_r   <= {q_r[NUM_W-2:0], fits};
      rem_r <= fits ? (shifted - {1'b0, den_r}) : shifted;
    end
  end

  assign quot = q_r;
  assign done = done_r;

endmodule

// ===== hw/rtl/tjh_bins.sv =====
// Bin counter store with per-entry valid bits and registered read.
`timescale 1ns / 1ps

module tjh_bins (
  input  logic                        clk,
  input  logic                        rst_n,
  input  tjh_pkg::bin_req_t           req,
  output logic [tjh_pkg::DATA_W-1:0]  rd_data
);

  logic [tjh_pkg::DATA_W-1:0]   mem_r [tjh_pkg::NUM_BINS];
  logic [tjh_pkg::NUM_BINS-1:0] vld_r;
  logic [tjh_pkg::DATA_W-1:0]   rd_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (req.wr_en) begin
      vld_r[req.addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem_r[req.addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data_r <= vld_r[req.addr] ? mem_r[req.addr] : '0;
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hw/rtl/tick_jitter_histogram_core.sv =====
// Top level of the tick jitter histogram: sequencer, datapath registers, config.
//
//   channel | ports                                  | handshake
//   --------+----------------------------------------+-------------------
//   in      | action, timestamp, bin_index           | in_valid / in_stall
//   out     | jitter_us, bin_hit, first_tick,        | out_valid / out_stall
//           | bin_count, tick_total                  |
//   cfg     | cfg_index, cfg_wdata                   | cfg_wr_en
//
// Tick: the shared divider first divides out the nominal period over RATE_W bits,
// then the interval over NUM_W = 32 + bits(100000 / TICKS_PER_SECOND) bits (39
// at the default), followed by the two divider handoffs, jitter, classify, bin update
// and output load. Read: bin read, then output load; a first tick goes straight to output load.
// Input is taken again in the cycle after the result is loaded; one transaction
// in flight at a time. rst_n is synchronous; all bins read as zero after reset.
// A finished result waits in the output register while out_stall is high.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tick_jitter_histogram_core #(
  parameter int TICKS_PER_SECOND = tjh_pkg::TICKS_PER_SECOND_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_action,
  input  logic [tjh_pkg::DATA_W-1:0]      in_timestamp,
  input  logic [tjh_pkg::BIN_W-1:0]       in_bin_index,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [tjh_pkg::DATA_W-1:0]      out_jitter_us,
  output logic [tjh_pkg::BIN_W-1:0]       out_bin_hit,
  output logic                            out_first_tick,
  output logic [tjh_pkg::DATA_W-1:0]      out_bin_count,
  output logic [tjh_pkg::DATA_W-1:0]      out_tick_total,
  input  logic                            cfg_wr_en,
  input  logic [tjh_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tjh_pkg::DATA_W-1:0]      cfg_wdata
);

  localparam int DW      = tjh_pkg::DATA_W;
  localparam int RW      = tjh_pkg::RATE_W;
  localparam int BW      = tjh_pkg::BIN_W;
  localparam int SCALE   = tjh_pkg::US_SCALE / TICKS_PER_SECOND;
  localparam int SCALE_W = $clog2(SCALE + 1);
  localparam int NUM_W   = DW + SCALE_W;
  localparam int DEN_W   = 2 * DW - tjh_pkg::RECIP10_SHIFT;

  typedef enum logic [2:0] {
    S_IDLE, S_NOM, S_INT, S_JIT, S_BIN, S_INC, S_RDW, S_EMIT
  } state_t;

  state_t                 state_r;
  logic [RW-1:0]          rate_r;
  logic [DW-1:0]          cpj_r;
  logic [DW-1:0]          prev_r;
  logic [DW-1:0]          sample_r;
  logic                   first_r;
  logic [DW-1:0]          total_r;
  logic [2*DW-1:0]        den_prod_r;
  logic [NUM_W-1:0]       prod_r;
  logic [RW-1:0]          nominal_r;
  logic [DW-1:0]          dt_r;
  logic [DW-1:0]          jitter_r;
  logic [BW-1:0]          hit_r;
  logic                   res_first_r;
  logic [DW-1:0]          count_r;
  logic                   out_valid_r;
  logic [DW-1:0]          out_jitter_us_r;
  logic [BW-1:0]          out_bin_hit_r;
  logic                   out_first_tick_r;
  logic [DW-1:0]          out_bin_count_r;
  logic [DW-1:0]          out_tick_total_r;

  logic                   in_acc;
  tjh_pkg::div_cmd_t      div_cmd;
  logic [NUM_W-1:0]       div_num;
  logic [DW-1:0]          div_den;
  logic [NUM_W-1:0]       div_q;
  logic                   div_done;
  tjh_pkg::bin_req_t      bin_req;
  logic [DW-1:0]          bin_rd;
  logic [RW-1:0]          rate_eff;
  logic [DEN_W-1:0]       den_raw;
  logic [DEN_W-1:0]       den_eff;
  logic [DW-1:0]          nom32;

  assign in_acc   = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);
  assign rate_eff = (rate_r == '0) ? RW'(1) : rate_r;
  assign den_raw  = den_prod_r[2*DW-1:tjh_pkg::RECIP10_SHIFT];
  assign den_eff  = (den_raw == '0) ? DEN_W'(1) : den_raw;
  assign nom32    = {{(DW-RW){1'b0}}, nominal_r};

  always_comb begin
    div_cmd = '0;
    if (state_r == S_IDLE && in_acc && in_action == tjh_pkg::ACT_TICK && !first_r) begin
      div_cmd.start     = 1'b1;
      div_cmd.short_run = 1'b1;
    end else if (state_r == S_NOM && div_done) begin
      div_cmd.start = 1'b1;
    end
    div_num = div_cmd.short_run ? {{(NUM_W-RW){1'b0}}, tjh_pkg::NOMINAL_NUM} : prod_r;
    div_den = div_cmd.short_run ? {{(DW-RW){1'b0}}, rate_eff}
                                : {{(DW-DEN_W){1'b0}}, den_eff};
  end

  always_comb begin
    bin_req = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc && in_action == tjh_pkg::ACT_READ) begin
          bin_req.rd_en = 1'b1;
          bin_req.addr  = in_bin_index;
        end
      end
      S_BIN: begin
        bin_req.rd_en = 1'b1;
        bin_req.addr  = tjh_pkg::classify(jitter_r);
      end
      S_INC: begin
        bin_req.wr_en   = 1'b1;
        bin_req.addr    = hit_r;
        bin_req.wr_data = bin_rd + 1'b1;
      end
      default: ;
    endcase
  end

  tjh_div #(
    .NUM_W (NUM_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (div_cmd),
    .num   (div_num),
    .den   (div_den),
    .quot  (div_q),
    .done  (div_done)
  );

  tjh_bins u_bins (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (bin_req),
    .rd_data (bin_rd)
  );

  // multiplier operands are stable while the nominal period is divided, unless cpj_r is written
  always_ff @(posedge clk) begin
    den_prod_r <= {{DW{1'b0}}, cpj_r} * {{DW{1'b0}}, tjh_pkg::RECIP10};
    prod_r     <= {{SCALE_W{1'b0}}, sample_r - prev_r} * NUM_W'(SCALE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r          <= S_IDLE;
      rate_r           <= tjh_pkg::SAMPLE_RATE_RST;
      cpj_r            <= tjh_pkg::CPJ_RST;
      prev_r           <= '0;
      first_r          <= 1'b1;
      total_r          <= DW'(1);
      out_valid_r      <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_index)
          tjh_pkg::CFG_SAMPLE_RATE:      rate_r <= cfg_wdata[RW-1:0];
          tjh_pkg::CFG_CYCLES_PER_JIFFY: cpj_r  <= cfg_wdata;
          default: ;
        endcase
      end
      if (state_r == S_EMIT && (!out_valid_r || !out_stall)) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            jitter_r    <= '0;
            hit_r       <= '0;
            count_r     <= '0;
            res_first_r <= (in_action == tjh_pkg::ACT_TICK) && first_r;
            if (in_action == tjh_pkg::ACT_TICK) begin
              total_r  <= total_r + 1'b1;
              sample_r <= in_timestamp;
              if (first_r) begin
                first_r     <= 1'b0;
                prev_r      <= in_timestamp;
                state_r     <= S_EMIT;
              end else begin
                state_r <= S_NOM;
              end
            end else begin
              state_r <= S_RDW;
            end
          end
        end
        S_NOM: begin
          if (div_done) begin
            nominal_r <= div_q[RW-1:0];
            state_r   <= S_INT;
          end
        end
        S_INT: begin
          if (div_done) begin
            dt_r    <= (|div_q[NUM_W-1:DW]) ? '1 : div_q[DW-1:0];
            state_r <= S_JIT;
          end
        end
        S_JIT: begin
          jitter_r <= (dt_r >= nom32) ? (dt_r - nom32) : (nom32 - dt_r);
          state_r  <= S_BIN;
        end
        S_BIN: begin
          hit_r   <= tjh_pkg::classify(jitter_r);
          state_r <= S_INC;
        end
        S_INC: begin
          prev_r  <= sample_r;
          state_r <= S_EMIT;
        end
        S_RDW: begin
          count_r <= bin_rd;
          state_r <= S_EMIT;
        end
        S_EMIT: begin
          if (!out_valid_r || !out_stall) begin
            out_jitter_us_r  <= jitter_r;
            out_bin_hit_r    <= hit_r;
            out_first_tick_r <= res_first_r;
            out_bin_count_r  <= count_r;
            out_tick_total_r <= total_r;
            state_r          <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid      = out_valid_r;
  assign out_jitter_us  = out_jitter_us_r;
  assign out_bin_hit    = out_bin_hit_r;
  assign out_first_tick = out_first_tick_r;
  assign out_bin_count  = out_bin_count_r;
  assign out_tick_total = out_tick_total_r;

  `TJH_ASSERT(a_accept_busy, clk, rst_n, in_acc |=> in_stall)
  `TJH_ASSERT(a_div_done_state, clk, rst_n, div_done |-> (state_r == S_NOM || state_r == S_INT))
  `TJH_ASSERT_MSG(a_first_clean, clk, rst_n,
    (out_valid_r && out_first_tick_r) |-> (out_jitter_us_r == '0 && out_bin_hit_r == '0),
    "first tick carries a bin")

endmodule

// ===== tb/tick_jitter_histogram_core_tb.sv =====
// Self-checking testbench for the tick jitter histogram core with a scoreboard class.
`timescale 1ns / 1ps

module tick_jitter_histogram_core_tb;

  localparam int unsigned US_PER_TICK = 100000 / tjh_pkg::TICKS_PER_SECOND_DEF;
  localparam int unsigned SETTLE_CYCLES = 90;
  localparam int unsigned PHASE_ITEMS = 215;
  localparam logic [31:0] JITTER_EDGES [16] = '{
    32'd0, 32'd1, 32'd2, 32'd5, 32'd10, 32'd20, 32'd50, 32'd100, 32'd200,
    32'd500, 32'd1000, 32'd2000, 32'd5000, 32'd10000, 32'd20000, 32'd50000
  };

  typedef struct packed {
    logic [31:0] jitter_us;
    logic [3:0]  bin_hit;
    logic        first_tick;
    logic [31:0] bin_count;
    logic [31:0] tick_total;
  } jitter_result_t;

  class histogram_tracker;
    logic [19:0]    rate_hz;
    logic [31:0]    cycles_per_jiffy;
    logic [31:0]    prev_sample;
    logic           awaiting_first;
    logic [31:0]    total_ticks;
    logic [31:0]    bin_counts [16];
    jitter_result_t pending [$];
    int             errors;

    function new();
      rate_hz = 20'd1000;
      cycles_per_jiffy = 32'd1000000;
      prev_sample = '0;
      awaiting_first = 1'b1;
      total_ticks = 32'd1;
      foreach (bin_counts[i]) bin_counts[i] = '0;
      errors = 0;
    endfunction

    function void note_input(logic act, logic [31:0] stamp, logic [3:0] idx);
      jitter_result_t r;
      logic [63:0]    divisor;
      logic [63:0]    quotient;
      logic [31:0]    interval;
      logic [31:0]    nominal;
      logic [19:0]    rate;
      r = '0;
      if (act == tjh_pkg::ACT_TICK) begin
        total_ticks = total_ticks + 32'd1;
        if (awaiting_first) begin
          awaiting_first = 1'b0;
          r.first_tick = 1'b1;
        end else begin
          divisor = {32'b0, cycles_per_jiffy / 32'd10};
          if (divisor == 64'd0) divisor = 64'd1;
          quotient = (64'(US_PER_TICK) * {32'b0, stamp - prev_sample}) / divisor;
          interval = (quotient > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : quotient[31:0];
          rate = (rate_hz == 20'd0) ? 20'd1 : rate_hz;
          nominal = 32'd1000000 / {12'b0, rate};
          r.jitter_us = (interval >= nominal) ? interval - nominal : nominal - interval;
          for (int i = 1; i < 16; i++)
            if (r.jitter_us >= JITTER_EDGES[i]) r.bin_hit = 4'(i);
          bin_counts[r.bin_hit] = bin_counts[r.bin_hit] + 32'd1;
        end
        prev_sample = stamp;
      end else begin
        r.bin_count = bin_counts[idx];
      end
      r.tick_total = total_ticks;
      pending.push_back(r);
    endfunction

    function void check_result(jitter_result_t got);
      jitter_result_t exp_r;
      if (pending.size() == 0) begin
        $error("result with no transaction outstanding");
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      if (got.jitter_us !== exp_r.jitter_us) begin
        $error("jitter_us mismatch: expected %0d, actual %0d", exp_r.jitter_us, got.jitter_us);
        errors++;
      end
      if (got.bin_hit !== exp_r.bin_hit) begin
        $error("bin_hit mismatch: expected %0d, actual %0d", exp_r.bin_hit, got.bin_hit);
        errors++;
      end
      if (got.first_tick !== exp_r.first_tick) begin
        $error("first_tick mismatch: expected %0d, actual %0d", exp_r.first_tick,
               got.first_tick);
        errors++;
      end
      if (got.bin_count !== exp_r.bin_count) begin
        $error("bin_count mismatch: expected %0d, actual %0d", exp_r.bin_count, got.bin_count);
        errors++;
      end
      if (got.tick_total !== exp_r.tick_total) begin
        $error("tick_total mismatch: expected %0d, actual %0d", exp_r.tick_total,
               got.tick_total);
        errors++;
      end
    endfunction
  endclass

  logic                          clk;
  logic                          rst_n;
  logic                          in_valid;
  logic                          in_stall;
  logic                          in_action;
  logic [tjh_pkg::DATA_W-1:0]    in_timestamp;
  logic [tjh_pkg::BIN_W-1:0]     in_bin_index;
  logic                          out_valid;
  logic                          out_stall;
  logic [tjh_pkg::DATA_W-1:0]    out_jitter_us;
  logic [tjh_pkg::BIN_W-1:0]     out_bin_hit;
  logic                          out_first_tick;
  logic [tjh_pkg::DATA_W-1:0]    out_bin_count;
  logic [tjh_pkg::DATA_W-1:0]    out_tick_total;
  logic                          cfg_wr_en;
  logic [tjh_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [tjh_pkg::DATA_W-1:0]    cfg_wdata;

  histogram_tracker tracker;
  int unsigned      send_idle_pct;
  int unsigned      stall_pct;
  int unsigned      hold_req;
  int unsigned      hold_left;
  logic [31:0]      last_stamp;
  logic [19:0]      rate_cfg;
  logic [31:0]      cpj_cfg;

  tick_jitter_histogram_core i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_action     (in_action),
    .in_timestamp  (in_timestamp),
    .in_bin_index  (in_bin_index),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_jitter_us (out_jitter_us),
    .out_bin_hit   (out_bin_hit),
    .out_first_tick(out_first_tick),
    .out_bin_count (out_bin_count),
    .out_tick_total(out_tick_total),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // result side: random stall, or a long hold-off when one is requested
  initial begin
    out_stall = 1'b0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req = 0;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      tracker.check_result('{jitter_us: out_jitter_us, bin_hit: out_bin_hit,
                             first_tick: out_first_tick, bin_count: out_bin_count,
                             tick_total: out_tick_total});
  end

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_item(input logic act, input logic [31:0] stamp, input logic [3:0] idx);
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 90)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_action <= act;
    in_timestamp <= stamp;
    in_bin_index <= idx;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    tracker.note_input(act, stamp, idx);
    if (act == tjh_pkg::ACT_TICK) last_stamp = stamp;
    @(negedge clk);
  endtask

  task automatic wait_all_results();
    while (tracker.pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic program_regs(input logic [31:0] rate_word, input logic [31:0] cpj_word);
    cfg_wr_en <= 1'b1;
    cfg_index <= tjh_pkg::CFG_SAMPLE_RATE;
    cfg_wdata <= rate_word;
    @(negedge clk);
    cfg_index <= tjh_pkg::CFG_CYCLES_PER_JIFFY;
    cfg_wdata <= cpj_word;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    tracker.rate_hz = rate_word[19:0];
    tracker.cycles_per_jiffy = cpj_word;
    rate_cfg = rate_word[19:0];
    cpj_cfg = cpj_word;
  endtask

  initial begin
    #15_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    logic [31:0]      rate_words [6];
    logic [31:0]      cpj_words [6];
    int unsigned      idle_modes [6];
    int unsigned      stall_modes [6];
    int unsigned      pick;
    int unsigned      b;
    logic [31:0]      j;
    logic [31:0]      target;
    logic [31:0]      nominal;
    logic [63:0]      divisor;
    logic [63:0]      want;
    logic [31:0]      stamp;

    tracker = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_action = tjh_pkg::ACT_TICK;
    in_timestamp = '0;
    in_bin_index = '0;
    cfg_wr_en = 1'b0;
    cfg_index = tjh_pkg::CFG_SAMPLE_RATE;
    cfg_wdata = '0;
    send_idle_pct = 0;
    stall_pct = 0;
    hold_req = 0;
    last_stamp = '0;
    rate_cfg = 20'd1000;
    cpj_cfg = 32'd1000000;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    repeat (2) @(negedge clk);

    // directed: reset settings, empty bins, first tick, jitter in several bin edge regions
    send_item(tjh_pkg::ACT_READ, 32'hFFFF_FFFF, 4'd0);
    send_item(tjh_pkg::ACT_READ, 32'h0, 4'd15);
    send_item(tjh_pkg::ACT_TICK, 32'hFFFF_FFF0, 4'd15);
    send_item(tjh_pkg::ACT_TICK, last_stamp + 32'd1000000, 4'd0);
    send_item(tjh_pkg::ACT_TICK, last_stamp + 32'd1001000, 4'd0);
    send_item(tjh_pkg::ACT_TICK, last_stamp + 32'd1002000, 4'd0);
    send_item(tjh_pkg::ACT_TICK, last_stamp + 32'd998000, 4'd0);
    send_item(tjh_pkg::ACT_TICK, last_stamp + 32'd1005000, 4'd0);
    send_item(tjh_pkg::ACT_TICK, last_stamp, 4'd0);
    send_item(tjh_pkg::ACT_TICK, last_stamp + 32'd51000000, 4'd0);
    send_item(tjh_pkg::ACT_TICK, 32'h0, 4'd0);
    send_item(tjh_pkg::ACT_TICK, 32'hFFFF_FFFF, 4'd0);
    send_item(tjh_pkg::ACT_TICK, last_stamp + 32'd1000999, 4'd0);
    send_item(tjh_pkg::ACT_READ, 32'h0, 4'd0);
    send_item(tjh_pkg::ACT_READ, 32'h0, 4'd1);
    send_item(tjh_pkg::ACT_READ, 32'h0, 4'd2);
    send_item(tjh_pkg::ACT_READ, 32'h0, 4'd3);
    send_item(tjh_pkg::ACT_READ, 32'h0, 4'd7);
    send_item(tjh_pkg::ACT_READ, 32'h0, 4'd10);
    send_item(tjh_pkg::ACT_READ, 32'h0, 4'd15);
    in_valid <= 1'b0;
    wait_all_results();

    // zero rate and divisor below one: saturated interval
    program_regs(32'hFFF0_0000, 32'd0);
    send_item(tjh_pkg::ACT_TICK, last_stamp + 32'hFFFF_FFFF, 4'd0);
    send_item(tjh_pkg::ACT_TICK, last_stamp + 32'd1, 4'd0);
    send_item(tjh_pkg::ACT_READ, 32'h0, 4'd15);
    in_valid <= 1'b0;
    wait_all_results();

    rate_words = '{32'd1, 32'd1000000, 32'hFFF0_0000, 32'hFFFF_FFFF, 32'd1000,
                   32'($urandom_range(1, 1000000))};
    cpj_words = '{32'd10, 32'hFFFF_FFFF, 32'd9, 32'd123456, 32'd1000000,
                  32'($urandom_range(10, 32'hFFFF_FFFF))};
    idle_modes = '{0, 73, 0, 10, 0, 73};
    stall_modes = '{0, 0, 73, 10, 0, 73};

    for (int p = 0; p < 6; p++) begin
      program_regs(rate_words[p], cpj_words[p]);
      send_idle_pct = idle_modes[p];
      stall_pct = stall_modes[p];
      if (p == 4) hold_req = 400;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        pick = $urandom_range(99);
        if (pick < 15) begin
          send_item(tjh_pkg::ACT_READ, $urandom, 4'($urandom));
        end else if (pick < 27) begin
          case ($urandom_range(2))
            0: stamp = $urandom;
            1: stamp = last_stamp;
            default: stamp = last_stamp + 32'($urandom_range(50));
          endcase
          send_item(tjh_pkg::ACT_TICK, stamp, 4'($urandom));
        end else begin
          // aim the interval at a chosen bin around the nominal period
          b = $urandom_range(15);
          j = JITTER_EDGES[b] + 32'($urandom_range((b == 15) ? 200000 :
                                    JITTER_EDGES[b+1] - JITTER_EDGES[b] - 1));
          nominal = 32'd1000000 / ((rate_cfg == 20'd0) ? 32'd1 : {12'b0, rate_cfg});
          if ($urandom_range(1) == 1 && j <= nominal) target = nominal - j;
          else target = nominal + j;
          divisor = {32'b0, cpj_cfg / 32'd10};
          if (divisor == 64'd0) divisor = 64'd1;
          want = ({32'b0, target} * divisor + 64'(US_PER_TICK) - 64'd1) / 64'(US_PER_TICK);
          if (want > 64'hFFFF_FFFF) want = {32'b0, $urandom};
          send_item(tjh_pkg::ACT_TICK, last_stamp + want[31:0], 4'($urandom));
        end
      end
      in_valid <= 1'b0;
      wait_all_results();
    end

    if (tracker.pending.size() != 0) begin
      $error("%0d expected results never arrived", tracker.pending.size());
      tracker.errors++;
    end
    if (tracker.errors == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/tjh_pkg.sv
hw/rtl/tjh_div.sv
hw/rtl/tjh_bins.sv
hw/rtl/tick_jitter_histogram_core.sv
tb/tick_jitter_histogram_core_tb.sv
